FILE: hdl/ghc_pkg.sv
// Package for the goal horizon clamp: CORDIC angle table, gain constant,
// and the word types passed between the pipeline cells. No dependencies.
`default_nettype none
package ghc_pkg;
   localparam int AngTableLen = 30;
   localparam int GuardBits   = 8;
   // Inverse CORDIC gain 0.60725293501 in Q0.30.
   localparam logic [29:0] GainInvQ30 = 30'd652032874;
   // Half-angle rotation seed: gain >> (30 - 14 - guard bits).
   localparam logic [29:0] QuatSeed = GainInvQ30 >> (30 - 14 - GuardBits);
   localparam logic [31:0] HalfTurn = 32'h8000_0000;
   localparam logic [31:0] QuarterTurn = 32'h4000_0000;
   localparam int CsrAddrBits = 1;
   localparam logic [CsrAddrBits-1:0] RegHorizon = 1'b0;
   localparam logic [30:0] HorizonReset = 31'd655360;

   // Vectoring works on 49-bit differences scaled by 2^16, plus growth.
   localparam int VecW = 52;
   // Position rotation: h * gain in Q.. with guard bits, plus growth.
   localparam int RotW = 42;

   typedef struct packed {
      logic [31:0] start_x;
      logic [31:0] start_y;
      logic [31:0] goal_x;
      logic [31:0] goal_y;
      logic [15:0] goal_qx;
      logic [15:0] goal_qy;
      logic [15:0] goal_qz;
      logic [15:0] goal_qw;
      logic        clamp;
      logic [30:0] horizon;
   } item_type;

   typedef struct packed {
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic [31:0]            z;
   } vec_type;

   typedef struct packed {
      logic signed [RotW-1:0] px;
      logic signed [RotW-1:0] py;
      logic [31:0]            pz;
      logic signed [RotW-1:0] qx;
      logic signed [RotW-1:0] qy;
      logic [31:0]            qz;
      logic                   flip;
   } rot_type;

   function automatic logic [31:0] ang_step(input int i);
      logic [31:0] t [AngTableLen];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
      return t[i];
   endfunction
endpackage
`default_nettype wire

FILE: hdl/goal_horizon_clamp.sv
// Top level of the goal horizon clamp: distance test, vectoring and rotation
// cell chains, output rounding and saturation. Depends on ghc_pkg and the cells.
//
//   port group | direction | word contents
//   req_       | in        | start_x, start_y, goal_x, goal_y, goal_qx..goal_qw
//   rsp_       | out       | new_x, new_y, new_qx..new_qw; tuser = clamped
//   csr_       | in/out    | horizon limit at byte address 0
//
// One word enters per cycle unless rsp_ stalls; each passes stages A and B, N vectoring
// cells, stage D, N rotation cells and the output register, N = min(CORDIC_STAGES, 30).
// Reset is synchronous and clears all valid flags and sets the horizon to 10.0.
// A stall on rsp_tready freezes the whole pipeline; req_tready follows it.
`default_nettype none
module goal_horizon_clamp #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // start_x[31:0], start_y[63:32], goal_x[95:64], goal_y[127:96],
   // goal_qx[143:128], goal_qy[159:144], goal_qz[175:160], goal_qw[191:176]
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_x[31:0], new_y[63:32], new_qx[79:64], new_qy[95:80],
   // new_qz[111:96], new_qw[127:112]
   output logic [127:0]      rsp_tdata,
   // clamped[0]
   output logic              rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [ghc_pkg::CsrAddrBits+1:0] csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import ghc_pkg::*;
   localparam int N = (CORDIC_STAGES > AngTableLen) ? AngTableLen : CORDIC_STAGES;

   logic [30:0] horizon_ff;
   logic        en;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= HorizonReset;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CsrAddrBits+1:2] == RegHorizon) begin
         horizon_ff <= csr_pwdata[30:0];
      end
   end
   assign csr_prdata = (csr_paddr[CsrAddrBits+1:2] == RegHorizon) ? {1'b0, horizon_ff} : 32'd0;

   // Pipeline advances unless a result is held and not taken.
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Stage A: differences and magnitudes.
   item_type              a_item_ff;
   logic                  a_valid_ff;
   logic signed [32:0]    a_dx_ff, a_dy_ff;
   logic [32:0]           a_ax_ff, a_ay_ff;
   logic signed [32:0]    dx_in, dy_in;
   always_comb begin
      dx_in = 33'(signed'(req_tdata[95:64]))  - 33'(signed'(req_tdata[31:0]));
      dy_in = 33'(signed'(req_tdata[127:96])) - 33'(signed'(req_tdata[63:32]));
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
      if (en) begin
         a_item_ff.start_x <= req_tdata[31:0];
         a_item_ff.start_y <= req_tdata[63:32];
         a_item_ff.goal_x  <= req_tdata[95:64];
         a_item_ff.goal_y  <= req_tdata[127:96];
         a_item_ff.goal_qx <= req_tdata[143:128];
         a_item_ff.goal_qy <= req_tdata[159:144];
         a_item_ff.goal_qz <= req_tdata[175:160];
         a_item_ff.goal_qw <= req_tdata[191:176];
         a_item_ff.clamp   <= 1'b0;
         a_item_ff.horizon <= horizon_ff;
         a_dx_ff <= dx_in;
         a_dy_ff <= dy_in;
         a_ax_ff <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
         a_ay_ff <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
      end
   end

   // Stage B: squares (one 31x31 multiplier each; the result is used only when
   // both magnitudes fit within 31 bits, so 31x31 suffices).
   item_type           b_item_ff;
   logic               b_valid_ff, b_big_ff;
   logic [61:0]        b_sx_ff, b_sy_ff, b_hh_ff;
   logic signed [32:0] b_dx_ff, b_dy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_item_ff <= a_item_ff;
         b_big_ff  <= (a_ax_ff > 33'(a_item_ff.horizon)) ||
                      (a_ay_ff > 33'(a_item_ff.horizon));
         b_sx_ff   <= a_ax_ff[30:0] * a_ax_ff[30:0];
         b_sy_ff   <= a_ay_ff[30:0] * a_ay_ff[30:0];
         b_hh_ff   <= a_item_ff.horizon * a_item_ff.horizon;
         b_dx_ff   <= a_dx_ff;
         b_dy_ff   <= a_dy_ff;
      end
   end

   // Stage C: clamp decision and vectoring seed with half-turn pre-rotation.
   item_type c_item;
   vec_type  c_vec;
   always_comb begin
      c_item = b_item_ff;
      c_item.clamp = b_big_ff || ({1'b0, b_sx_ff} + {1'b0, b_sy_ff} > {1'b0, b_hh_ff});
      c_vec.x = VecW'(b_dx_ff) <<< 16;
      c_vec.y = VecW'(b_dy_ff) <<< 16;
      c_vec.z = 32'd0;
      if (b_dx_ff < 0) begin
         c_vec.x = -c_vec.x;
         c_vec.y = -c_vec.y;
         c_vec.z = HalfTurn;
      end
   end

   logic     vv [N+1];
   vec_type  vd [N+1];
   item_type vi [N+1];
   assign vv[0] = b_valid_ff;
   assign vd[0] = c_vec;
   assign vi[0] = c_item;
   for (genvar g = 0; g < N; g++) begin : g_vec
      ghc_vec_cell #(.STAGE(g)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_in(vv[g]), .vec_in(vd[g]), .item_in(vi[g]),
         .valid_out(vv[g+1]), .vec_out(vd[g+1]), .item_out(vi[g+1]));
   end

   // Stage D: seeds for both rotations (multiply h by gain, registered).
   logic        d_valid_ff, d_flip_ff;
   item_type    d_item_ff;
   logic [31:0] d_pang_ff, d_half_ff;
   logic [60:0] d_hg_ff;
   logic [31:0] theta;
   logic        flip_c;
   assign theta  = vd[N].z;
   assign flip_c = ((theta + QuarterTurn) & HalfTurn) != 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= vv[N];
      end
      if (en) begin
         d_item_ff <= vi[N];
         d_flip_ff <= flip_c;
         d_pang_ff <= flip_c ? theta + HalfTurn : theta;
         d_half_ff <= {theta[31], theta[31:1]};
         d_hg_ff   <= vi[N].horizon * GainInvQ30;
      end
   end

   rot_type r0;
   always_comb begin
      r0.px   = RotW'(d_hg_ff[60:30-GuardBits]);
      r0.py   = '0;
      r0.pz   = d_pang_ff;
      r0.qx   = RotW'(QuatSeed);
      r0.qy   = '0;
      r0.qz   = d_half_ff;
      r0.flip = d_flip_ff;
   end

   logic     rv [N+1];
   rot_type  rd [N+1];
   item_type ri [N+1];
   assign rv[0] = d_valid_ff;
   assign rd[0] = r0;
   assign ri[0] = d_item_ff;
   for (genvar g = 0; g < N; g++) begin : g_rot
      ghc_rot_cell #(.STAGE(g)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_in(rv[g]), .rot_in(rd[g]), .item_in(ri[g]),
         .valid_out(rv[g+1]), .rot_out(rd[g+1]), .item_out(ri[g+1]));
   end

   // Output stage: round off guard bits, add to start, saturate.
   logic signed [RotW-1:0] cx, cy, rw, rz;
   logic signed [RotW:0]   nx, ny;
   logic signed [15:0]     qw_s, qz_s;
   item_type               fi;
   assign fi = ri[N];
   always_comb begin
      cx = rd[N].flip ? -rd[N].px : rd[N].px;
      cy = rd[N].flip ? -rd[N].py : rd[N].py;
      cx = (cx + RotW'(1 << (GuardBits-1))) >>> GuardBits;
      cy = (cy + RotW'(1 << (GuardBits-1))) >>> GuardBits;
      rw = (rd[N].qx + RotW'(1 << (GuardBits-1))) >>> GuardBits;
      rz = (rd[N].qy + RotW'(1 << (GuardBits-1))) >>> GuardBits;
      nx = (RotW+1)'(signed'(fi.start_x)) + (RotW+1)'(cx);
      ny = (RotW+1)'(signed'(fi.start_y)) + (RotW+1)'(cy);
      qw_s = (rw > 16384) ? 16'sd16384 : (rw < -16384) ? -16'sd16384 : 16'(rw);
      qz_s = (rz > 16384) ? 16'sd16384 : (rz < -16384) ? -16'sd16384 : 16'(rz);
   end

   function automatic logic [31:0] sat32(input logic signed [RotW:0] v);
      if (v > (RotW+1)'(32'sh7FFFFFFF)) begin
         return 32'h7FFF_FFFF;
      end else if (v < -(RotW+1)'(33'sh080000000)) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   logic         out_valid_ff;
   logic [127:0] out_data_ff;
   logic         out_clamp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= rv[N];
      end
      if (en) begin
         out_clamp_ff <= fi.clamp;
         if (fi.clamp) begin
            out_data_ff <= {qw_s, qz_s, 16'd0, 16'd0, sat32(ny), sat32(nx)};
         end else begin
            out_data_ff <= {fi.goal_qw, fi.goal_qz, fi.goal_qy, fi.goal_qx,
                            fi.goal_y, fi.goal_x};
         end
      end
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_clamp_ff;

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow the output stall");
   a_clamp_qxy_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[95:64] == 32'd0)
      else $error("clamped word carries nonzero quaternion x or y");
   a_clamp_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> ($signed(rsp_tdata[127:112]) <= 16'sd16384) &&
                                  ($signed(rsp_tdata[127:112]) >= -16'sd16384))
      else $error("clamped word has w outside the unit range");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed during stall");
endmodule
`default_nettype wire

FILE: hdl/ghc_vec_cell.sv
// One CORDIC vectoring micro-rotation cell with its item carried alongside.
// Depends on ghc_pkg.
`default_nettype none
module ghc_vec_cell #(
   parameter int STAGE = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             valid_in,
   input  ghc_pkg::vec_type      vec_in,
   input  ghc_pkg::item_type     item_in,
   output logic                  valid_out,
   output ghc_pkg::vec_type      vec_out,
   output ghc_pkg::item_type     item_out
);
   import ghc_pkg::*;
   logic    valid_ff;
   vec_type vec_ff, vec_in_n;
   item_type item_ff;

   always_comb begin
      vec_in_n = vec_in;
      if (vec_in.y < 0) begin
         vec_in_n.x = vec_in.x - (vec_in.y >>> STAGE);
         vec_in_n.y = vec_in.y + (vec_in.x >>> STAGE);
         vec_in_n.z = vec_in.z - ang_step(STAGE);
      end else begin
         vec_in_n.x = vec_in.x + (vec_in.y >>> STAGE);
         vec_in_n.y = vec_in.y - (vec_in.x >>> STAGE);
         vec_in_n.z = vec_in.z + ang_step(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         vec_ff  <= vec_in_n;
         item_ff <= item_in;
      end
   end

   assign valid_out = valid_ff;
   assign vec_out   = vec_ff;
   assign item_out  = item_ff;
endmodule
`default_nettype wire

FILE: hdl/ghc_rot_cell.sv
// One cell holding both CORDIC rotation micro-steps: goal offset and half-angle.
// Depends on ghc_pkg.
`default_nettype none
module ghc_rot_cell #(
   parameter int STAGE = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             valid_in,
   input  ghc_pkg::rot_type      rot_in,
   input  ghc_pkg::item_type     item_in,
   output logic                  valid_out,
   output ghc_pkg::rot_type      rot_out,
   output ghc_pkg::item_type     item_out
);
   import ghc_pkg::*;
   logic     valid_ff;
   rot_type  rot_ff, rot_in_n;
   item_type item_ff;

   always_comb begin
      rot_in_n = rot_in;
      if (rot_in.pz[31]) begin
         rot_in_n.px = rot_in.px + (rot_in.py >>> STAGE);
         rot_in_n.py = rot_in.py - (rot_in.px >>> STAGE);
         rot_in_n.pz = rot_in.pz + ang_step(STAGE);
      end else begin
         rot_in_n.px = rot_in.px - (rot_in.py >>> STAGE);
         rot_in_n.py = rot_in.py + (rot_in.px >>> STAGE);
         rot_in_n.pz = rot_in.pz - ang_step(STAGE);
      end
      if (rot_in.qz[31]) begin
         rot_in_n.qx = rot_in.qx + (rot_in.qy >>> STAGE);
         rot_in_n.qy = rot_in.qy - (rot_in.qx >>> STAGE);
         rot_in_n.qz = rot_in.qz + ang_step(STAGE);
      end else begin
         rot_in_n.qx = rot_in.qx - (rot_in.qy >>> STAGE);
         rot_in_n.qy = rot_in.qy + (rot_in.qx >>> STAGE);
         rot_in_n.qz = rot_in.qz - ang_step(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         rot_ff  <= rot_in_n;
         item_ff <= item_in;
      end
   end

   assign valid_out = valid_ff;
   assign rot_out   = rot_ff;
   assign item_out  = item_ff;
endmodule
`default_nettype wire
